// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define CHK_HOLDS(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/lacm_pkg.sv =====
// Package: widths, types, codes and rounding helpers of the look-at matrix unit.
package lacm_pkg;

	localparam int POS_WIDTH = 32;
	localparam int ROT_FRAC_BITS = 14;
	localparam int ROT_WIDTH = 16;
	localparam int INNER_BITS = 30;
	localparam int ROWS = 3;

	localparam int RED_WIDTH = INNER_BITS + 1;
	localparam int SH_WIDTH = $clog2(POS_WIDTH + 1);
	localparam int RSQ_WIDTH = 2 * RED_WIDTH;
	localparam int FSQ_WIDTH = 2 * POS_WIDTH;
	localparam int RAD_WIDTH = FSQ_WIDTH + 2;
	localparam int TGT_WIDTH = RSQ_WIDTH + 2 * INNER_BITS + 2;
	localparam int ROOT_STEPS = POS_WIDTH;
	localparam int ROOT_WIDTH = ROOT_STEPS;
	localparam int ACC_WIDTH = 2 * ROOT_STEPS + RAD_WIDTH + 6;
	localparam int QV_WIDTH = ROOT_WIDTH + 1;
	localparam int PROD_WIDTH = 2 * QV_WIDTH;
	localparam int K_UNIT = INNER_BITS - ROT_FRAC_BITS;
	localparam int K_PROD = 2 * INNER_BITS - ROT_FRAC_BITS;
	localparam int ROT_LIM = ((1 << ROT_FRAC_BITS) > 32767) ? 32767 : (1 << ROT_FRAC_BITS);

	localparam logic [1:0] ROW_SIDE = 2'd0;
	localparam logic [1:0] ROW_UP = 2'd1;
	localparam logic [1:0] ROW_LOOK = 2'd2;

	typedef logic [POS_WIDTH-1:0] mag_t;
	typedef logic signed [POS_WIDTH-1:0] pos_t;
	typedef logic [RED_WIDTH-1:0] red_t;
	typedef logic [SH_WIDTH-1:0] sh_t;
	typedef logic [RSQ_WIDTH-1:0] rsq_t;
	typedef logic [FSQ_WIDTH-1:0] fsq_t;
	typedef logic [RAD_WIDTH-1:0] rad_t;
	typedef logic [TGT_WIDTH-1:0] tgt_t;
	typedef logic signed [ACC_WIDTH-1:0] acc_t;
	typedef logic [ROOT_WIDTH-1:0] root_t;
	typedef logic signed [QV_WIDTH-1:0] qv_t;
	typedef logic signed [PROD_WIDTH-1:0] prod_t;
	typedef logic signed [ROT_WIDTH-1:0] rot_t;

	typedef enum logic [1:0] {PH_IDLE, PH_UP, PH_LOOK} phase_t;

	typedef struct packed {
		logic neg_x;
		logic neg_y;
		logic neg_z;
		logic degen;
		logic sat;
	} side_t;

	function automatic sh_t fit_shift(input mag_t m);
		sh_t sh;
		sh = '0;
		for (int i = RED_WIDTH; i < POS_WIDTH; i++) begin
			if (m[i]) begin
				sh = sh_t'(i - RED_WIDTH + 1);
			end
		end
		return sh;
	endfunction

	function automatic rot_t to_rot(input logic signed [63:0] v, input int k);
		logic [63:0] m;
		logic [63:0] r;
		m = v[63] ? 64'(-v) : 64'(v);
		r = (m + (64'd1 << (k - 1))) >> k;
		if (r > 64'(ROT_LIM)) begin
			r = 64'(ROT_LIM);
		end
		if (v[63]) begin
			r = -r;
		end
		return rot_t'(r[ROT_WIDTH-1:0]);
	endfunction

endpackage

// ===== sv/lacm_root_lane.sv =====
// Pipelined root search: largest m with (2m-1)^2 * rad <= tgt, one bit per stage.
module lacm_root_lane (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  lacm_pkg::rad_t        rad,
	input  lacm_pkg::tgt_t        tgt,
	output logic                  out_valid,
	output lacm_pkg::root_t       root
);

	logic                vld_s  [lacm_pkg::ROOT_STEPS];
	lacm_pkg::root_t     root_s [lacm_pkg::ROOT_STEPS];
	lacm_pkg::acc_t      sq_s   [lacm_pkg::ROOT_STEPS];
	lacm_pkg::acc_t      lin_s  [lacm_pkg::ROOT_STEPS];
	lacm_pkg::rad_t      rad_s  [lacm_pkg::ROOT_STEPS];
	lacm_pkg::tgt_t      tgt_s  [lacm_pkg::ROOT_STEPS];

	for (genvar i = 0; i < lacm_pkg::ROOT_STEPS; i++) begin : g_step
		localparam int K = lacm_pkg::ROOT_STEPS - 1 - i;
		logic            pv;
		lacm_pkg::root_t pr;
		lacm_pkg::acc_t  psq;
		lacm_pkg::acc_t  plin;
		lacm_pkg::rad_t  prad;
		lacm_pkg::tgt_t  ptgt;
		lacm_pkg::acc_t  dw;
		lacm_pkg::acc_t  tw;
		lacm_pkg::acc_t  sq_c;
		lacm_pkg::acc_t  lin_c;
		logic            take;

		if (i == 0) begin : g_head
			assign pv = in_valid;
			assign pr = '0;
			assign prad = rad;
			assign ptgt = tgt;
			assign psq = lacm_pkg::acc_t'(rad);
			assign plin = -lacm_pkg::acc_t'(rad);
		end else begin : g_body
			assign pv = vld_s[i-1];
			assign pr = root_s[i-1];
			assign prad = rad_s[i-1];
			assign ptgt = tgt_s[i-1];
			assign psq = sq_s[i-1];
			assign plin = lin_s[i-1];
		end

		assign dw = lacm_pkg::acc_t'(prad);
		assign tw = lacm_pkg::acc_t'(ptgt);
		assign sq_c = psq + (plin <<< (K + 2)) + (dw <<< (2 * K + 2));
		assign lin_c = plin + (dw <<< (K + 1));
		assign take = (sq_c <= tw);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else begin
				vld_s[i] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			rad_s[i] <= prad;
			tgt_s[i] <= ptgt;
			root_s[i] <= take ? (pr | (lacm_pkg::root_t'(1) << K)) : pr;
			sq_s[i] <= take ? sq_c : psq;
			lin_s[i] <= take ? lin_c : plin;
		end
	end

	assign out_valid = vld_s[lacm_pkg::ROOT_STEPS-1];
	assign root = root_s[lacm_pkg::ROOT_STEPS-1];

endmodule

// ===== sv/look_at_camera_matrix_unit.sv =====
// Top level: look-at view matrix from a camera position, three row words per position.
//
//  channel   | handshake          | words
//  ----------+--------------------+-------------------------------------------------
//  position  | start / busy       | pos_x, pos_y, pos_z
//  row       | done (one cycle)   | row_index, rot_first..third, shift, degenerate,
//            |                    | last_row
//
// A position is taken when start is high and busy is low; busy then stays high while
// a hold counter runs down, so rows never overlap; one row word per cycle.
// The first row appears after stages s1..s5, the 32 root stages (one result bit per
// stage), stages e1..e3 and the output register; the up and look rows then follow.
// Reset clears all valid bits and the row sequencer; no clearing pass.
// Rows cannot be held off: done marks each row word for exactly one cycle.
module look_at_camera_matrix_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  lacm_pkg::pos_t        pos_x,
	input  lacm_pkg::pos_t        pos_y,
	input  lacm_pkg::pos_t        pos_z,
	output logic                  done,
	output logic [1:0]            row_index,
	output lacm_pkg::rot_t        rot_first,
	output lacm_pkg::rot_t        rot_second,
	output lacm_pkg::rot_t        rot_third,
	output lacm_pkg::pos_t        shift,
	output logic                  degenerate,
	output logic                  last_row
);

	logic            accept;
	logic [1:0]      hold_q;

	logic            v_s1, v_s2, v_s3, v_s4, v_s5;
	lacm_pkg::pos_t  x_s1, y_s1, z_s1;
	lacm_pkg::mag_t  mx_s2, my_s2, mz_s2;
	lacm_pkg::side_t side_s2, side_s3, side_s4, side_s5;
	lacm_pkg::mag_t  mxz, mall;
	lacm_pkg::sh_t   shl, shs;
	lacm_pkg::red_t  rx_s3, ry_s3, rz_s3, sx_s3, sz_s3;
	lacm_pkg::mag_t  mx_s3, my_s3, mz_s3;
	lacm_pkg::rsq_t  rx2_s4, ry2_s4, rz2_s4, sx2_s4, sz2_s4;
	lacm_pkg::fsq_t  fx2_s4, fy2_s4, fz2_s4;
	lacm_pkg::rad_t  dd_c;
	lacm_pkg::rad_t  dl_s5, ds_s5, dd_s5;
	lacm_pkg::rsq_t  rx2_s5, ry2_s5, rz2_s5, sx2_s5, sz2_s5;

	logic [5:0]      lane_v;
	lacm_pkg::root_t m_p0, m_p1, m_p2, m_s0, m_s2, m_tr;
	lacm_pkg::side_t side_d [lacm_pkg::ROOT_STEPS];
	logic            v_r;

	logic            v_e1, v_e2, v_e3;
	lacm_pkg::side_t side_e1, side_e2;
	lacm_pkg::qv_t   p0_e1, p1_e1, p2_e1, s0_e1, s2_e1;
	lacm_pkg::pos_t  tr_e1, tr_e2, tr_e3;
	lacm_pkg::prod_t pa_e2, pb_e2, pc_e2, pd_e2;
	lacm_pkg::rot_t  r00_e2, r02_e2, r20_e2, r21_e2, r22_e2;
	lacm_pkg::rot_t  bank_e3 [lacm_pkg::ROWS][lacm_pkg::ROWS];
	logic            degen_e3;

	lacm_pkg::phase_t phase_q, phase_d;
	logic            emit;
	logic [1:0]      row_d;
	lacm_pkg::rot_t  f1, f2, f3;
	lacm_pkg::pos_t  fsh;

	assign accept = start && !busy;
	assign busy = (hold_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 2'd0;
		end else if (accept) begin
			hold_q <= 2'(lacm_pkg::ROWS - 1);
		end else if (hold_q != 2'd0) begin
			hold_q <= hold_q - 2'd1;
		end
	end

	// valid bits of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	assign mxz = (mx_s2 > mz_s2) ? mx_s2 : mz_s2;
	assign mall = (mxz > my_s2) ? mxz : my_s2;
	assign shl = lacm_pkg::fit_shift(mall);
	assign shs = lacm_pkg::fit_shift(mxz);
	assign dd_c = lacm_pkg::rad_t'(fx2_s4) + lacm_pkg::rad_t'(fy2_s4)
		+ lacm_pkg::rad_t'(fz2_s4);

	always_ff @(posedge clk) begin
		x_s1 <= pos_x;
		y_s1 <= pos_y;
		z_s1 <= pos_z;

		mx_s2 <= x_s1[lacm_pkg::POS_WIDTH-1] ? lacm_pkg::mag_t'(-x_s1) : lacm_pkg::mag_t'(x_s1);
		my_s2 <= y_s1[lacm_pkg::POS_WIDTH-1] ? lacm_pkg::mag_t'(-y_s1) : lacm_pkg::mag_t'(y_s1);
		mz_s2 <= z_s1[lacm_pkg::POS_WIDTH-1] ? lacm_pkg::mag_t'(-z_s1) : lacm_pkg::mag_t'(z_s1);
		side_s2.neg_x <= x_s1[lacm_pkg::POS_WIDTH-1];
		side_s2.neg_y <= y_s1[lacm_pkg::POS_WIDTH-1];
		side_s2.neg_z <= z_s1[lacm_pkg::POS_WIDTH-1];
		side_s2.degen <= (x_s1 == '0) && (z_s1 == '0);
		side_s2.sat <= 1'b0;

		rx_s3 <= lacm_pkg::red_t'(mx_s2 >> shl);
		ry_s3 <= lacm_pkg::red_t'(my_s2 >> shl);
		rz_s3 <= lacm_pkg::red_t'(mz_s2 >> shl);
		sx_s3 <= lacm_pkg::red_t'(mx_s2 >> shs);
		sz_s3 <= lacm_pkg::red_t'(mz_s2 >> shs);
		mx_s3 <= mx_s2;
		my_s3 <= my_s2;
		mz_s3 <= mz_s2;
		side_s3 <= side_s2;

		rx2_s4 <= lacm_pkg::rsq_t'(rx_s3) * lacm_pkg::rsq_t'(rx_s3);
		ry2_s4 <= lacm_pkg::rsq_t'(ry_s3) * lacm_pkg::rsq_t'(ry_s3);
		rz2_s4 <= lacm_pkg::rsq_t'(rz_s3) * lacm_pkg::rsq_t'(rz_s3);
		sx2_s4 <= lacm_pkg::rsq_t'(sx_s3) * lacm_pkg::rsq_t'(sx_s3);
		sz2_s4 <= lacm_pkg::rsq_t'(sz_s3) * lacm_pkg::rsq_t'(sz_s3);
		fx2_s4 <= lacm_pkg::fsq_t'(mx_s3) * lacm_pkg::fsq_t'(mx_s3);
		fy2_s4 <= lacm_pkg::fsq_t'(my_s3) * lacm_pkg::fsq_t'(my_s3);
		fz2_s4 <= lacm_pkg::fsq_t'(mz_s3) * lacm_pkg::fsq_t'(mz_s3);
		side_s4 <= side_s3;

		dl_s5 <= lacm_pkg::rad_t'(rx2_s4) + lacm_pkg::rad_t'(ry2_s4) + lacm_pkg::rad_t'(rz2_s4);
		ds_s5 <= lacm_pkg::rad_t'(sx2_s4) + lacm_pkg::rad_t'(sz2_s4);
		dd_s5 <= dd_c;
		rx2_s5 <= rx2_s4;
		ry2_s5 <= ry2_s4;
		rz2_s5 <= rz2_s4;
		sx2_s5 <= sx2_s4;
		sz2_s5 <= sz2_s4;
		side_s5 <= '{neg_x: side_s4.neg_x, neg_y: side_s4.neg_y, neg_z: side_s4.neg_z,
			degen: side_s4.degen,
			sat: |dd_c[lacm_pkg::RAD_WIDTH-1:lacm_pkg::FSQ_WIDTH-2]};
	end

	lacm_root_lane u_lane_p0 (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s5), .rad(dl_s5),
		.tgt(lacm_pkg::tgt_t'(rx2_s5) << (2 * lacm_pkg::INNER_BITS + 2)),
		.out_valid(lane_v[0]), .root(m_p0)
	);
	lacm_root_lane u_lane_p1 (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s5), .rad(dl_s5),
		.tgt(lacm_pkg::tgt_t'(ry2_s5) << (2 * lacm_pkg::INNER_BITS + 2)),
		.out_valid(lane_v[1]), .root(m_p1)
	);
	lacm_root_lane u_lane_p2 (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s5), .rad(dl_s5),
		.tgt(lacm_pkg::tgt_t'(rz2_s5) << (2 * lacm_pkg::INNER_BITS + 2)),
		.out_valid(lane_v[2]), .root(m_p2)
	);
	lacm_root_lane u_lane_s0 (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s5), .rad(ds_s5),
		.tgt(lacm_pkg::tgt_t'(sz2_s5) << (2 * lacm_pkg::INNER_BITS + 2)),
		.out_valid(lane_v[3]), .root(m_s0)
	);
	lacm_root_lane u_lane_s2 (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s5), .rad(ds_s5),
		.tgt(lacm_pkg::tgt_t'(sx2_s5) << (2 * lacm_pkg::INNER_BITS + 2)),
		.out_valid(lane_v[4]), .root(m_s2)
	);
	lacm_root_lane u_lane_tr (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s5), .rad(lacm_pkg::rad_t'(1)),
		.tgt(lacm_pkg::tgt_t'(dd_s5) << 2),
		.out_valid(lane_v[5]), .root(m_tr)
	);

	assign v_r = &lane_v;

	always_ff @(posedge clk) begin
		side_d[0] <= side_s5;
		for (int j = 1; j < lacm_pkg::ROOT_STEPS; j++) begin
			side_d[j] <= side_d[j-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_e1 <= 1'b0;
			v_e2 <= 1'b0;
			v_e3 <= 1'b0;
		end else begin
			v_e1 <= v_r;
			v_e2 <= v_e1;
			v_e3 <= v_e2;
		end
	end

	always_ff @(posedge clk) begin
		side_e1 <= side_d[lacm_pkg::ROOT_STEPS-1];
		p0_e1 <= side_d[lacm_pkg::ROOT_STEPS-1].neg_x ? -lacm_pkg::qv_t'(m_p0)
			: lacm_pkg::qv_t'(m_p0);
		p1_e1 <= side_d[lacm_pkg::ROOT_STEPS-1].neg_y ? -lacm_pkg::qv_t'(m_p1)
			: lacm_pkg::qv_t'(m_p1);
		p2_e1 <= side_d[lacm_pkg::ROOT_STEPS-1].neg_z ? -lacm_pkg::qv_t'(m_p2)
			: lacm_pkg::qv_t'(m_p2);
		s0_e1 <= side_d[lacm_pkg::ROOT_STEPS-1].neg_z ? -lacm_pkg::qv_t'(m_s0)
			: lacm_pkg::qv_t'(m_s0);
		s2_e1 <= side_d[lacm_pkg::ROOT_STEPS-1].neg_x ? lacm_pkg::qv_t'(m_s2)
			: -lacm_pkg::qv_t'(m_s2);
		tr_e1 <= side_d[lacm_pkg::ROOT_STEPS-1].sat
			? lacm_pkg::pos_t'(lacm_pkg::mag_t'(1) << (lacm_pkg::POS_WIDTH - 1))
			: lacm_pkg::pos_t'(-m_tr);

		side_e2 <= side_e1;
		pa_e2 <= lacm_pkg::prod_t'(s2_e1) * lacm_pkg::prod_t'(p1_e1);
		pb_e2 <= lacm_pkg::prod_t'(s0_e1) * lacm_pkg::prod_t'(p2_e1);
		pc_e2 <= lacm_pkg::prod_t'(s2_e1) * lacm_pkg::prod_t'(p0_e1);
		pd_e2 <= lacm_pkg::prod_t'(s0_e1) * lacm_pkg::prod_t'(p1_e1);
		r00_e2 <= lacm_pkg::to_rot(64'(s0_e1), lacm_pkg::K_UNIT);
		r02_e2 <= lacm_pkg::to_rot(64'(s2_e1), lacm_pkg::K_UNIT);
		r20_e2 <= lacm_pkg::to_rot(64'(p0_e1), lacm_pkg::K_UNIT);
		r21_e2 <= lacm_pkg::to_rot(64'(p1_e1), lacm_pkg::K_UNIT);
		r22_e2 <= lacm_pkg::to_rot(64'(p2_e1), lacm_pkg::K_UNIT);
		tr_e2 <= tr_e1;

		// hold the row bank while its rows go out
		if (v_e2) begin
			degen_e3 <= side_e2.degen;
			if (side_e2.degen) begin
				for (int r = 0; r < lacm_pkg::ROWS; r++) begin
					for (int c = 0; c < lacm_pkg::ROWS; c++) begin
						bank_e3[r][c] <= '0;
					end
				end
				tr_e3 <= '0;
			end else begin
				bank_e3[0][0] <= r00_e2;
				bank_e3[0][1] <= '0;
				bank_e3[0][2] <= r02_e2;
				bank_e3[1][0] <= lacm_pkg::to_rot(64'(pa_e2), lacm_pkg::K_PROD);
				bank_e3[1][1] <= lacm_pkg::to_rot(64'(pb_e2 - pc_e2), lacm_pkg::K_PROD);
				bank_e3[1][2] <= lacm_pkg::to_rot(64'(-pd_e2), lacm_pkg::K_PROD);
				bank_e3[2][0] <= r20_e2;
				bank_e3[2][1] <= r21_e2;
				bank_e3[2][2] <= r22_e2;
				tr_e3 <= tr_e2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lacm_pkg::PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		emit = 1'b0;
		row_d = lacm_pkg::ROW_SIDE;
		unique case (phase_q)
			lacm_pkg::PH_IDLE: begin
				if (v_e3) begin
					emit = 1'b1;
					phase_d = lacm_pkg::PH_UP;
				end
			end
			lacm_pkg::PH_UP: begin
				emit = 1'b1;
				row_d = lacm_pkg::ROW_UP;
				phase_d = lacm_pkg::PH_LOOK;
			end
			lacm_pkg::PH_LOOK: begin
				emit = 1'b1;
				row_d = lacm_pkg::ROW_LOOK;
				phase_d = lacm_pkg::PH_IDLE;
			end
			default: begin
				phase_d = lacm_pkg::PH_IDLE;
			end
		endcase
	end

	always_comb begin
		f1 = bank_e3[0][0];
		f2 = bank_e3[0][1];
		f3 = bank_e3[0][2];
		fsh = '0;
		case (row_d)
			lacm_pkg::ROW_UP: begin
				f1 = bank_e3[1][0];
				f2 = bank_e3[1][1];
				f3 = bank_e3[1][2];
			end
			lacm_pkg::ROW_LOOK: begin
				f1 = bank_e3[2][0];
				f2 = bank_e3[2][1];
				f3 = bank_e3[2][2];
				fsh = tr_e3;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= emit;
		end
	end

	always_ff @(posedge clk) begin
		row_index <= row_d;
		rot_first <= f1;
		rot_second <= f2;
		rot_third <= f3;
		shift <= fsh;
		degenerate <= degen_e3;
		last_row <= (row_d == lacm_pkg::ROW_LOOK);
	end

endmodule

// ===== sv/lacm_checker.sv =====
// Port checker for the look-at matrix unit and its bind.
`include "assert_macros.svh"

module lacm_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input logic [1:0]     row_index,
	input lacm_pkg::rot_t rot_first,
	input lacm_pkg::rot_t rot_second,
	input lacm_pkg::rot_t rot_third,
	input lacm_pkg::pos_t shift,
	input logic           degenerate,
	input logic           last_row
);

	`CHK_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "no busy after accept")
	`CHK_NEXT(a_row_order, clk, arst_n, done && row_index == lacm_pkg::ROW_SIDE, done && row_index == lacm_pkg::ROW_UP && !last_row, "up row missing after side row")
	`CHK_HOLDS(a_last_row, clk, arst_n, done, last_row == (row_index == lacm_pkg::ROW_LOOK), "last_row mismatch")
	`CHK_HOLDS(a_degen_zero, clk, arst_n, done && degenerate, rot_first == 0 && rot_second == 0 && rot_third == 0 && shift == 0, "degenerate word not zero")
	`CHK_HOLDS(a_shift_rows, clk, arst_n, done && row_index != lacm_pkg::ROW_LOOK, shift == 0, "shift on rotation-only row")

endmodule

bind look_at_camera_matrix_unit lacm_checker u_lacm_checker (.*);
